### rtl/actc_pkg.sv
package actc_pkg;

  localparam int unsigned DAY_TICKS      = 864000;
  localparam int unsigned TONE_ON_TICKS  = 8;
  localparam int unsigned TONE_OFF_TICKS = 5;
  localparam int unsigned MIN_TONES      = 5;

  localparam int unsigned TIME_W  = 20;
  localparam int unsigned CAD_W   = $clog2(TONE_ON_TICKS + TONE_OFF_TICKS + 1);
  localparam int unsigned TONES_W = 8;

  localparam logic [TIME_W-1:0]  DAY_LIMIT = TIME_W'(DAY_TICKS);
  localparam logic [TIME_W-1:0]  DAY_LAST  = TIME_W'(DAY_TICKS - 1);
  localparam logic [CAD_W-1:0]   CAD_LAST  = CAD_W'(TONE_ON_TICKS + TONE_OFF_TICKS);
  localparam logic [CAD_W-1:0]   CAD_ON    = CAD_W'(TONE_ON_TICKS);
  localparam logic [TONES_W-1:0] TONES_MIN = TONES_W'(MIN_TONES);
  localparam logic [TONES_W-1:0] TONES_MAX = {TONES_W{1'b1}};

  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_ARMED     = 2'd1;
  localparam logic [1:0] MODE_TRIGGERED = 2'd2;
  localparam logic [1:0] MODE_RUNNING   = 2'd3;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  localparam logic REG_ALARM = 1'b0;
  localparam logic REG_START = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic               tone;
    logic [CAD_W-1:0]   cadence;
    logic [TONES_W-1:0] tones;
    logic [TIME_W-1:0]  day;
  } actc_state_t;

endpackage

### rtl/alarm_clock_tone_controller_unit.sv
// A request is taken into the input register; its result is then registered in the result register behind out_tvalid.
// Throughput: one request per cycle, set by the single update stage; a stalled result
// holds both registers, and in_tready drops once the input register is also full.
// State is updated once per request in the stage between input and result registers.
// Reset (rst_n low, synchronous) clears control state, alarm state and both config
// registers; the result channel comes out of reset empty.
module alarm_clock_tone_controller_unit import actc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] motion, [1] button
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] mode, [2] tone_on, [22:3] time_now
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic              s1_motion_r;
  logic              s1_button_r;
  logic              out_valid_r;
  logic [23:0]       out_data_r;
  logic [TIME_W-1:0] alarm_ticks_r;
  logic [TIME_W-1:0] start_ticks_r;
  actc_state_t       state_r;
  actc_state_t       state_nxt;
  logic              advance;
  logic              cfg_wr;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {{(32 - TIME_W){1'b0}},
                       (cfg_paddr[2] == REG_START) ? start_ticks_r : alarm_ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_ticks_r <= '0;
      start_ticks_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ALARM) begin
        alarm_ticks_r <= cfg_pwdata[TIME_W-1:0];
      end else begin
        start_ticks_r <= cfg_pwdata[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r   <= in_tuser;
      s1_motion_r <= in_tdata[0];
      s1_button_r <= in_tdata[1];
    end
  end

  actc_step u_step (
    .state_i     (state_r),
    .kind        (s1_kind_r),
    .motion      (s1_motion_r),
    .button      (s1_button_r),
    .alarm_ticks (alarm_ticks_r),
    .start_ticks (start_ticks_r),
    .state_o     (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_IDLE, tone: 1'b0, cadence: '0, tones: '0, day: '0};
    end else if (advance && s1_valid_r) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= {1'b0, state_nxt.day, state_nxt.tone, state_nxt.mode};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.day < DAY_LIMIT)
    else $error("day counter out of range");

  a_idle_day: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_IDLE |-> state_r.day == '0)
    else $error("day counter moved while idle");

  a_tone_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tone |-> (state_r.mode == MODE_TRIGGERED || state_r.mode == MODE_RUNNING))
    else $error("tone on outside triggered or running");

  a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_kind_r))
    else $error("pending request lost during stall");

endmodule

### rtl/actc_step.sv
module actc_step import actc_pkg::*; (
  input  actc_state_t       state_i,
  input  logic [1:0]        kind,
  input  logic              motion,
  input  logic              button,
  input  logic [TIME_W-1:0] alarm_ticks,
  input  logic [TIME_W-1:0] start_ticks,
  output actc_state_t       state_o
);

  logic [TIME_W-1:0] day_inc;

  assign day_inc = (state_i.day >= DAY_LAST) ? '0 : state_i.day + TIME_W'(1);

  always_comb begin
    state_o = state_i;
    case (kind)
      KIND_TICK: begin
        if (state_i.mode != MODE_IDLE) begin
          state_o.day = day_inc;
          if (day_inc == alarm_ticks) begin
            state_o.mode = MODE_TRIGGERED;
          end else if (state_i.mode == MODE_RUNNING) begin
            if (state_i.cadence < CAD_LAST) begin
              state_o.cadence = state_i.cadence + CAD_W'(1);
            end else begin
              state_o.cadence = '0;
              if (state_i.tones != TONES_MAX) begin
                state_o.tones = state_i.tones + TONES_W'(1);
              end
            end
          end else begin
            state_o.cadence = '0;
            state_o.tones   = '0;
          end
        end
      end
      KIND_START: begin
        state_o.day     = (start_ticks < DAY_LIMIT) ? start_ticks : '0;
        state_o.mode    = MODE_ARMED;
        state_o.tone    = 1'b0;
        state_o.cadence = '0;
        state_o.tones   = '0;
      end
      KIND_CHECK: begin
        if (state_i.mode == MODE_TRIGGERED) begin
          state_o.mode = MODE_RUNNING;
          state_o.tone = 1'b1;
        end else if (state_i.mode == MODE_RUNNING) begin
          if (button || (motion && (state_i.tones >= TONES_MIN))) begin
            state_o.mode = MODE_ARMED;
            state_o.tone = 1'b0;
          end else begin
            state_o.tone = (state_i.cadence < CAD_ON);
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule
